>>> hw/rtl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, framing constants and helpers for the printer command framer.
// ----------------------------------------------------------------------------
package pcf_pkg;

  // Framing bytes
  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] OPEN2_BYTE = 8'h50;  // 'P'
  localparam logic [7:0] CLOSE2_BYTE = 8'h5C; // backslash
  localparam logic [7:0] TAIL_BYTE  = 8'h10;
  localparam logic [7:0] CHECK_SEED = 8'hFF;

  // Input transfer payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_frame;
  } pcf_in_t;

  // Result transfer payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } pcf_out_t;

  // One classified command item, handed from front to back
  typedef struct packed {
    logic       hdr;       // open a frame first
    logic       has_data;  // pass data through
    logic       close;     // emit checksum and trailer after
    logic [7:0] data;
    logic [7:0] check;     // checksum to print when close is set
  } pcf_job_t;

  // Nibble to uppercase ASCII hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h41 + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/pcf_front.sv
// ----------------------------------------------------------------------------
// pcf_front
// Accepts command bytes, tracks the open frame and the running XOR checksum,
// and turns each item into one job for the back end.
// ----------------------------------------------------------------------------
module pcf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcf_pkg::pcf_in_t  in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output pcf_pkg::pcf_job_t job
);

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] check_r, check_nxt;
  logic [7:0] base_check;
  logic [7:0] data_term;
  logic       xfer;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign xfer      = in_valid && job_ready;

  // Classify the item and fold the byte into the checksum
  always_comb begin
    base_check   = in_frame_r ? check_r : pcf_pkg::CHECK_SEED;
    data_term    = in_data.empty_frame ? 8'h00 : in_data.data_byte;
    job.hdr      = !in_frame_r;
    job.has_data = !in_data.empty_frame;
    job.close    = in_data.empty_frame || in_data.last_byte;
    job.data     = in_data.data_byte;
    job.check    = base_check ^ data_term;

    in_frame_nxt = in_frame_r;
    check_nxt    = check_r;
    if (xfer) begin
      if (job.close) begin
        in_frame_nxt = 1'b0;
        check_nxt    = pcf_pkg::CHECK_SEED;
      end else begin
        in_frame_nxt = 1'b1;
        check_nxt    = job.check;
      end
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      check_r    <= pcf_pkg::CHECK_SEED;
    end else begin
      in_frame_r <= in_frame_nxt;
      check_r    <= check_nxt;
    end
  end

  // A closing transfer leaves no frame open
  a_close_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && (in_data.empty_frame || in_data.last_byte) |=> !in_frame_r)
    else $error("frame still open after closing transfer");

  // Checksum is back at its seed whenever no frame is open
  a_seed_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> check_r == pcf_pkg::CHECK_SEED)
    else $error("checksum not reseeded outside a frame");

endmodule

>>> hw/rtl/pcf_queue.sv
// ----------------------------------------------------------------------------
// pcf_queue
// Small register queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module pcf_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  pcf_pkg::pcf_job_t push_job,
  output logic              head_valid,
  input  logic              pop,
  output pcf_pkg::pcf_job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pcf_pkg::pcf_job_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Fill count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue overfilled");

endmodule

>>> hw/rtl/pcf_back.sv
// ----------------------------------------------------------------------------
// pcf_back
// Expands the job at the queue head into framed bytes, into the output
// register, one per cycle unless out_ready stalls it.
// ----------------------------------------------------------------------------
module pcf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  pcf_pkg::pcf_job_t head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output pcf_pkg::pcf_out_t out_data
);

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_DATA, ST_CK_HI, ST_CK_LO, ST_ESC, ST_BSL, ST_TAIL
  } step_t;

  step_t             step_r, cur_step, next_step;
  logic              started_r;
  logic              out_valid_r;
  pcf_pkg::pcf_out_t out_data_r;
  logic              emit, last_step;
  pcf_pkg::pcf_out_t emit_data;

  // First step of a fresh job, or where the current one left off
  always_comb begin
    if (started_r) begin
      cur_step = step_r;
    end else if (head_job.hdr) begin
      cur_step = ST_HDR0;
    end else if (head_job.has_data) begin
      cur_step = ST_DATA;
    end else begin
      cur_step = ST_CK_HI;
    end
  end

  // Byte for the current step and the step after it
  always_comb begin
    emit_data.frame_end = 1'b0;
    last_step           = 1'b0;
    case (cur_step)
      ST_HDR0: begin
        emit_data.out_byte = pcf_pkg::ESC_BYTE;
        next_step          = ST_HDR1;
      end
      ST_HDR1: begin
        emit_data.out_byte = pcf_pkg::OPEN2_BYTE;
        next_step          = head_job.has_data ? ST_DATA : ST_CK_HI;
      end
      ST_DATA: begin
        emit_data.out_byte = head_job.data;
        next_step          = ST_CK_HI;
        last_step          = !head_job.close;
      end
      ST_CK_HI: begin
        emit_data.out_byte = pcf_pkg::hex_digit(head_job.check[7:4]);
        next_step          = ST_CK_LO;
      end
      ST_CK_LO: begin
        emit_data.out_byte = pcf_pkg::hex_digit(head_job.check[3:0]);
        next_step          = ST_ESC;
      end
      ST_ESC: begin
        emit_data.out_byte = pcf_pkg::ESC_BYTE;
        next_step          = ST_BSL;
      end
      ST_BSL: begin
        emit_data.out_byte = pcf_pkg::CLOSE2_BYTE;
        next_step          = ST_TAIL;
      end
      ST_TAIL: begin
        emit_data.out_byte  = pcf_pkg::TAIL_BYTE;
        emit_data.frame_end = 1'b1;
        next_step           = ST_HDR0;
        last_step           = 1'b1;
      end
      default: begin
        emit_data.out_byte = pcf_pkg::ESC_BYTE;
        next_step          = ST_HDR0;
      end
    endcase
  end

  assign emit      = head_valid && (!out_valid_r || out_ready);
  assign pop       = emit && last_step;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_HDR0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= emit_data;
        started_r   <= !last_step;
        step_r      <= next_step;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A job in progress is still at the queue head
  a_started_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> head_valid)
    else $error("sequencer running without a job");

  // frame_end marks only the trailing byte
  a_frame_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_end |-> out_data_r.out_byte == pcf_pkg::TAIL_BYTE)
    else $error("frame_end on a byte other than the trailer");

  // The job is retired on the cycle its final byte is emitted
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !started_r)
    else $error("sequencer kept running after retiring a job");

endmodule

>>> hw/rtl/printer_command_framer_top.sv
// ----------------------------------------------------------------------------
// printer_command_framer_top
// Wraps command bytes in ESC 'P' ... checksum ESC '\' 0x10 frames.
// ----------------------------------------------------------------------------
//  channel  | ports                          | payload
//  ---------+--------------------------------+----------------------------------
//  input    | in_valid, in_ready, in_data    | data_byte, last_byte, empty_frame
//  result   | out_valid, out_ready, out_data | out_byte, frame_end
//
//  One output byte per cycle unless out_ready stalls. A mid-frame command
//  byte gives one byte; the first byte of a frame adds two header bytes and
//  a closing item adds five checksum/trailer bytes, set by the back-end byte
//  sequencer. An item goes through the job queue, then the out reg.
//  Reset (rst_n low, synchronous) closes any frame and empties the queue.
//  The front keeps accepting until the job queue fills; out_ready low stalls
//  only the back end.
// ----------------------------------------------------------------------------
module printer_command_framer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcf_pkg::pcf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pcf_pkg::pcf_out_t out_data
);

  logic              job_valid, job_ready;
  pcf_pkg::pcf_job_t job;
  logic              head_valid, pop;
  pcf_pkg::pcf_job_t head_job;

  pcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  pcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_job   (job),
    .head_valid (head_valid),
    .pop        (pop),
    .head_job   (head_job)
  );

  pcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for printer_command_framer_top: a directed table, then
// random frames, noise and stray empty-frame items. Every framed byte is
// scored, in transfer order, against a cycle-free model or a table literal.
// ----------------------------------------------------------------------------
module tb;

  localparam int DIRECTED_ROWS = 20;
  localparam int RANDOM_ITEMS  = 390;
  localparam int HOLD_AT_ITEM  = 140;  // long out_ready hold-off starts here
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_CYCLES  = 16;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  pcf_pkg::pcf_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pcf_pkg::pcf_out_t out_data;

  // Framer model state
  logic       mdl_open;
  logic [7:0] mdl_check;

  pcf_pkg::pcf_out_t pending_bytes[$];
  pcf_pkg::pcf_in_t  row_item[$];
  int                row_lit_n[$];
  logic [63:0]       row_lit[$];

  int fail_cnt   = 0;
  int items_acc  = 0;
  int burst_left = 0;

  printer_command_framer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
    return (nib > 4'd9) ? (8'h37 + {4'd0, nib}) : (8'h30 + {4'd0, nib});
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic fe);
    pcf_pkg::pcf_out_t r;
    r.out_byte  = b;
    r.frame_end = fe;
    pending_bytes.push_back(r);
  endtask

  // Model one accepted command item; queue its bytes when emit is set
  task automatic predict_frame_bytes(input pcf_pkg::pcf_in_t it, input bit emit);
    if (!mdl_open) begin
      if (emit) begin
        push_byte(pcf_pkg::ESC_BYTE, 1'b0);
        push_byte(pcf_pkg::OPEN2_BYTE, 1'b0);
      end
      mdl_open  = 1'b1;
      mdl_check = pcf_pkg::CHECK_SEED;
    end
    if (!it.empty_frame) begin
      if (emit) push_byte(it.data_byte, 1'b0);
      mdl_check = mdl_check ^ it.data_byte;
    end
    if (it.empty_frame || it.last_byte) begin
      if (emit) begin
        push_byte(ascii_nibble(mdl_check[7:4]), 1'b0);
        push_byte(ascii_nibble(mdl_check[3:0]), 1'b0);
        push_byte(pcf_pkg::ESC_BYTE, 1'b0);
        push_byte(pcf_pkg::CLOSE2_BYTE, 1'b0);
        push_byte(pcf_pkg::TAIL_BYTE, 1'b1);
      end
      mdl_open  = 1'b0;
      mdl_check = pcf_pkg::CHECK_SEED;
    end
  endtask

  // Directed row; lit_n > 0 gives the framed bytes, MSB first, ending a frame
  task automatic add_row(input logic [7:0] d, input logic lb, input logic ef,
                         input int lit_n, input logic [63:0] lit);
    pcf_pkg::pcf_in_t it;
    it.data_byte   = d;
    it.last_byte   = lb;
    it.empty_frame = ef;
    row_item.push_back(it);
    row_lit_n.push_back(lit_n);
    row_lit.push_back(lit);
  endtask

  // Offer one item in a burst/gap pattern and record it on transfer
  task automatic send_item(input pcf_pkg::pcf_in_t it, input int lit_n,
                           input logic [63:0] lit);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_data  <= pcf_pkg::pcf_in_t'(10'($urandom));
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_acc++;
    if (lit_n == 0) begin
      predict_frame_bytes(it, 1'b1);
    end else begin
      predict_frame_bytes(it, 1'b0);
      for (int k = 0; k < lit_n; k++) begin
        push_byte(lit[63 - 8*k -: 8], k == lit_n - 1);
      end
    end
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_plain(input logic [7:0] d, input logic lb, input logic ef);
    pcf_pkg::pcf_in_t it;
    it.data_byte   = d;
    it.last_byte   = lb;
    it.empty_frame = ef;
    send_item(it, 0, '0);
  endtask

  // Stimulus and end of run
  initial begin
    int len;
    int kind;
    mdl_open  = 1'b0;
    mdl_check = pcf_pkg::CHECK_SEED;

    // empty frame, none open
    add_row(8'hA5, 1'b1, 1'b1, 7, 64'h1B50_4646_1B5C_1000);
    // single-byte commands at the data extremes and an A..F checksum
    add_row(8'h00, 1'b1, 1'b0, 8, 64'h1B50_0046_461B_5C10);
    add_row(8'hFF, 1'b1, 1'b0, 8, 64'h1B50_FF30_301B_5C10);
    add_row(8'h55, 1'b1, 1'b0, 8, 64'h1B50_5541_411B_5C10);
    // multi-byte command
    add_row(8'h12, 1'b0, 1'b0, 0, '0);
    add_row(8'h34, 1'b0, 1'b0, 0, '0);
    add_row(8'h56, 1'b1, 1'b0, 0, '0);
    // empty frame closing an open one: checksum 7F
    add_row(8'h80, 1'b0, 1'b0, 0, '0);
    add_row(8'hFF, 1'b0, 1'b1, 5, 64'h3746_1B5C_1000_0000);
    // checksum back to zero
    add_row(8'h0F, 1'b0, 1'b0, 0, '0);
    add_row(8'hF0, 1'b1, 1'b0, 0, '0);
    // empty frame with last_byte low
    add_row(8'h00, 1'b0, 1'b1, 0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 0, '0);
    add_row(8'h00, 1'b0, 1'b0, 0, '0);
    add_row(8'hA5, 1'b1, 1'b0, 0, '0);
    // empty closing with last_byte also set
    add_row(8'h7E, 1'b0, 1'b0, 0, '0);
    add_row(8'h00, 1'b1, 1'b1, 0, '0);
    add_row(8'h01, 1'b1, 1'b0, 0, '0);
    add_row(8'h44, 1'b1, 1'b0, 0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < row_item.size(); i++) begin
      send_item(row_item[i], row_lit_n[i], row_lit[i]);
    end

    // Random part: mostly well-formed frames, some noise
    while (items_acc < DIRECTED_ROWS + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
        for (int k = 0; k < len - 1; k++) send_plain(rand_data(), 1'b0, 1'b0);
        if ($urandom_range(0, 9) == 0) begin
          send_plain(rand_data(), 1'b0, 1'b0);
          send_plain(8'($urandom), 1'($urandom), 1'b1);
        end else begin
          send_plain(rand_data(), 1'b1, 1'b0);
        end
      end else if (kind < 82) begin
        send_plain(8'($urandom), 1'($urandom), 1'b1);
      end else begin
        send_plain(8'($urandom), 1'($urandom), ($urandom_range(0, 5) == 0));
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side stall pattern, with one long hold-off
  initial begin
    int mode;
    int cyc;
    bit held;
    logic [7:0] pat;
    mode = 0;
    cyc  = 0;
    held = 1'b0;
    pat  = 8'b1011_0110;
    forever begin
      @(negedge clk);
      if (!held && items_acc >= HOLD_AT_ITEM) begin
        held = 1'b1;
        out_ready <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
      end else begin
        if (cyc % 48 == 0) mode = $urandom_range(0, 3);
        cyc++;
        pat = {pat[6:0], pat[7]};
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= pat[0];
        endcase
      end
    end
  end

  // Score each result transfer against the oldest expected byte
  always @(posedge clk) begin
    pcf_pkg::pcf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected transfer: out_byte=%h frame_end=%b",
               out_data.out_byte, out_data.frame_end);
        fail_cnt++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_data.out_byte);
          fail_cnt++;
        end
        if (out_data.frame_end !== want.frame_end) begin
          $error("frame_end: expected %b, actual %b", want.frame_end, out_data.frame_end);
          fail_cnt++;
        end
      end
    end
  end

endmodule

>>> files.f
hw/rtl/pcf_pkg.sv
hw/rtl/pcf_front.sv
hw/rtl/pcf_queue.sv
hw/rtl/pcf_back.sv
hw/rtl/printer_command_framer_top.sv
tb/tb.sv
